### src/lfmc_pkg.sv
`default_nettype none
package lfmc_pkg;

  localparam int SENSE_W = 10;
  localparam int POS_W   = 13;
  localparam int ERR_W   = 13;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  localparam logic [SENSE_W-1:0] FULL_READING    = 10'd1000;
  localparam logic [POS_W-1:0]   MAX_POSITION    = 13'd7000;
  localparam logic [POS_W:0]     CENTRE_POSITION = 14'd3500;

  localparam logic [IDX_W-1:0] REG_BASE_SPEED  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SLOW_SPEED  = 3'd1;
  localparam logic [IDX_W-1:0] REG_CREEP_SPEED = 3'd2;
  localparam logic [IDX_W-1:0] REG_KP          = 3'd3;
  localparam logic [IDX_W-1:0] REG_KD          = 3'd4;
  localparam logic [IDX_W-1:0] REG_CORR_LIMIT  = 3'd5;
  localparam logic [IDX_W-1:0] REG_LINE_THRESH = 3'd6;
  localparam logic [IDX_W-1:0] REG_CLEAR_LEVEL = 3'd7;

  localparam logic [7:0]         RST_BASE_SPEED  = 8'd130;
  localparam logic [7:0]         RST_SLOW_SPEED  = 8'd100;
  localparam logic [7:0]         RST_CREEP_SPEED = 8'd80;
  localparam logic [15:0]        RST_KP          = 16'd1311;
  localparam logic [15:0]        RST_KD          = 16'd0;
  localparam logic [6:0]         RST_CORR_LIMIT  = 7'd55;
  localparam logic [SENSE_W-1:0] RST_LINE_THRESH = 10'd500;
  localparam logic [SENSE_W-1:0] RST_CLEAR_LEVEL = 10'd100;

  typedef struct packed {
    logic [7:0]         base_speed;
    logic [7:0]         slow_speed;
    logic [7:0]         creep_speed;
    logic [15:0]        kp_q16;
    logic [15:0]        kd_q16;
    logic [6:0]         corr_clamp;
    logic [SENSE_W-1:0] line_threshold;
    logic [SENSE_W-1:0] clear_level;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]        position;
    logic signed [ERR_W-1:0] prev_error;
    logic                    first_sample;
  } pd_in_t;

  typedef struct packed {
    logic [7:0]              pwm_left;
    logic [7:0]              pwm_right;
    logic signed [ERR_W-1:0] error;
  } pd_out_t;

  typedef enum logic [6:0] {
    PH_FOLLOW       = 7'b0000001,
    PH_CREEP        = 7'b0000010,
    PH_LEFT_SWING   = 7'b0000100,
    PH_LEFT_SETTLE  = 7'b0001000,
    PH_RIGHT_SWING  = 7'b0010000,
    PH_RIGHT_SETTLE = 7'b0100000,
    PH_DONE         = 7'b1000000
  } phase_t;

endpackage
`default_nettype wire

### src/lfmc_pd.sv
`default_nettype none
module lfmc_pd (
  input  wire lfmc_pkg::cfg_t   cfg,
  input  wire lfmc_pkg::pd_in_t pd_in,
  output lfmc_pkg::pd_out_t     pd_out
);

  logic [lfmc_pkg::POS_W-1:0]          pos_c;
  logic signed [lfmc_pkg::POS_W:0]     err_w;
  logic signed [lfmc_pkg::ERR_W-1:0]   error;
  logic signed [lfmc_pkg::ERR_W:0]     diff;
  logic signed [29:0]                  p_term;
  logic signed [30:0]                  d_term;
  logic signed [31:0]                  sum;
  logic [31:0]                         abs_sum;
  logic [15:0]                         mag_hi;
  logic [6:0]                          mag;
  logic signed [7:0]                   corr;
  logic signed [9:0]                   left_w;
  logic signed [9:0]                   right_w;

  always_comb begin
    pos_c = (pd_in.position > lfmc_pkg::MAX_POSITION) ? lfmc_pkg::MAX_POSITION
                                                      : pd_in.position;
    err_w = $signed({1'b0, pos_c}) - $signed(lfmc_pkg::CENTRE_POSITION);
    error = err_w[lfmc_pkg::ERR_W-1:0];
    diff  = $signed({error[lfmc_pkg::ERR_W-1], error})
          - $signed({pd_in.prev_error[lfmc_pkg::ERR_W-1], pd_in.prev_error});
    p_term = $signed({1'b0, cfg.kp_q16}) * error;
    d_term = $signed({1'b0, cfg.kd_q16}) * diff;
    sum = $signed({{2{p_term[29]}}, p_term});
    if (!pd_in.first_sample) begin
      sum = sum + $signed({d_term[30], d_term});
    end
    abs_sum = sum[31] ? 32'(-sum) : 32'(sum);
    mag_hi  = abs_sum[31:16];
    mag     = (mag_hi > {9'd0, cfg.corr_clamp}) ? cfg.corr_clamp
                                                 : mag_hi[6:0];
    corr    = sum[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    left_w  = $signed({2'b00, cfg.base_speed}) - $signed({{2{corr[7]}}, corr});
    right_w = $signed({2'b00, cfg.base_speed}) + $signed({{2{corr[7]}}, corr});

    if (left_w < 0) begin
      pd_out.pwm_left = 8'd0;
    end else if (left_w > 10'sd255) begin
      pd_out.pwm_left = 8'd255;
    end else begin
      pd_out.pwm_left = left_w[7:0];
    end
    if (right_w < 0) begin
      pd_out.pwm_right = 8'd0;
    end else if (right_w > 10'sd255) begin
      pd_out.pwm_right = 8'd255;
    end else begin
      pd_out.pwm_right = right_w[7:0];
    end
    pd_out.error = error;
  end

endmodule
`default_nettype wire

### src/line_follow_motor_controller.sv
// A transferred sample is held in the sample register, which feeds the command
// register directly and hands it on when the result side is ready.
// Throughput: one sample per cycle if not stalled; PD and mode are combinational.
// Reset (synchronous, active low) empties both stages, restores the register
// defaults and returns to line following with the first-sample flag set.
`default_nettype none
module line_follow_motor_controller (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_write_en,
  input  wire [lfmc_pkg::IDX_W-1:0]          cfg_index,
  input  wire [lfmc_pkg::CFG_W-1:0]          cfg_data,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire [lfmc_pkg::SENSE_W-1:0]        in_sense_right_outer,
  input  wire [lfmc_pkg::SENSE_W-1:0]        in_sense_right_near,
  input  wire [lfmc_pkg::SENSE_W-1:0]        in_sense_right_mid,
  input  wire [lfmc_pkg::SENSE_W-1:0]        in_sense_right_centre,
  input  wire [lfmc_pkg::SENSE_W-1:0]        in_sense_left_centre,
  input  wire [lfmc_pkg::SENSE_W-1:0]        in_sense_left_mid,
  input  wire [lfmc_pkg::SENSE_W-1:0]        in_sense_left_near,
  input  wire [lfmc_pkg::SENSE_W-1:0]        in_sense_left_outer,
  input  wire [lfmc_pkg::POS_W-1:0]          in_line_position,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [7:0]                         out_pwm_left,
  output logic [7:0]                         out_pwm_right,
  output logic                               out_dir_left,
  output logic                               out_dir_right,
  output logic                               out_finished
);

  lfmc_pkg::cfg_t cfg_r;

  logic                             s1_valid_r;
  logic [lfmc_pkg::SENSE_W-1:0]     s_r [8];
  logic [lfmc_pkg::POS_W-1:0]       pos_r;

  lfmc_pkg::phase_t                 phase_r, phase_nxt;
  logic                             seen_left_r, seen_left_nxt;
  logic                             seen_right_r, seen_right_nxt;
  logic signed [lfmc_pkg::ERR_W-1:0] prev_err_r, prev_err_nxt;
  logic                             first_r, first_nxt;
  logic                             hdl_r, hdl_nxt;
  logic                             hdr_r, hdr_nxt;

  logic                             out_valid_r;
  logic [7:0]                       pwm_left_r, pwm_left_nxt;
  logic [7:0]                       pwm_right_r, pwm_right_nxt;
  logic                             dir_left_r, dir_right_r;
  logic                             fin_r, fin_nxt;

  logic                             adv;
  logic                             mark_left, mark_right;
  logic                             turn_left, swing;
  logic [lfmc_pkg::SENSE_W-1:0]     outer, centre;
  logic                             use_pd;

  lfmc_pkg::pd_in_t                 pd_in;
  lfmc_pkg::pd_out_t                pd_out;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  assign out_valid     = out_valid_r;
  assign out_pwm_left  = pwm_left_r;
  assign out_pwm_right = pwm_right_r;
  assign out_dir_left  = dir_left_r;
  assign out_dir_right = dir_right_r;
  assign out_finished  = fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_speed     <= lfmc_pkg::RST_BASE_SPEED;
      cfg_r.slow_speed     <= lfmc_pkg::RST_SLOW_SPEED;
      cfg_r.creep_speed    <= lfmc_pkg::RST_CREEP_SPEED;
      cfg_r.kp_q16         <= lfmc_pkg::RST_KP;
      cfg_r.kd_q16         <= lfmc_pkg::RST_KD;
      cfg_r.corr_clamp     <= lfmc_pkg::RST_CORR_LIMIT;
      cfg_r.line_threshold <= lfmc_pkg::RST_LINE_THRESH;
      cfg_r.clear_level    <= lfmc_pkg::RST_CLEAR_LEVEL;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        lfmc_pkg::REG_BASE_SPEED:  cfg_r.base_speed     <= cfg_data[7:0];
        lfmc_pkg::REG_SLOW_SPEED:  cfg_r.slow_speed     <= cfg_data[7:0];
        lfmc_pkg::REG_CREEP_SPEED: cfg_r.creep_speed    <= cfg_data[7:0];
        lfmc_pkg::REG_KP:          cfg_r.kp_q16         <= cfg_data[15:0];
        lfmc_pkg::REG_KD:          cfg_r.kd_q16         <= cfg_data[15:0];
        lfmc_pkg::REG_CORR_LIMIT:  cfg_r.corr_clamp     <= cfg_data[6:0];
        lfmc_pkg::REG_LINE_THRESH: cfg_r.line_threshold <= cfg_data[9:0];
        lfmc_pkg::REG_CLEAR_LEVEL: cfg_r.clear_level    <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_r[0] <= in_sense_right_outer;
      s_r[1] <= in_sense_right_near;
      s_r[2] <= in_sense_right_mid;
      s_r[3] <= in_sense_right_centre;
      s_r[4] <= in_sense_left_centre;
      s_r[5] <= in_sense_left_mid;
      s_r[6] <= in_sense_left_near;
      s_r[7] <= in_sense_left_outer;
      pos_r  <= in_line_position;
    end
  end

  assign pd_in.position     = pos_r;
  assign pd_in.prev_error   = prev_err_r;
  assign pd_in.first_sample = first_r;

  lfmc_pd u_pd (
    .cfg    (cfg_r),
    .pd_in  (pd_in),
    .pd_out (pd_out)
  );

  always_comb begin
    mark_right = (s_r[0] == lfmc_pkg::FULL_READING) && (s_r[1] == lfmc_pkg::FULL_READING)
              && (s_r[2] == lfmc_pkg::FULL_READING);
    mark_left  = (s_r[7] == lfmc_pkg::FULL_READING) && (s_r[6] == lfmc_pkg::FULL_READING)
              && (s_r[5] == lfmc_pkg::FULL_READING);
    turn_left = (phase_r == lfmc_pkg::PH_LEFT_SWING) || (phase_r == lfmc_pkg::PH_LEFT_SETTLE);
    swing     = (phase_r == lfmc_pkg::PH_LEFT_SWING) || (phase_r == lfmc_pkg::PH_RIGHT_SWING);
    outer     = turn_left ? s_r[7] : s_r[0];
    centre    = turn_left ? s_r[4] : s_r[3];

    phase_nxt      = phase_r;
    seen_left_nxt  = seen_left_r;
    seen_right_nxt = seen_right_r;
    prev_err_nxt   = prev_err_r;
    first_nxt      = first_r;
    hdl_nxt        = hdl_r;
    hdr_nxt        = hdr_r;
    pwm_left_nxt   = 8'd0;
    pwm_right_nxt  = 8'd0;
    fin_nxt        = 1'b0;
    use_pd         = 1'b0;

    unique case (phase_r) inside
      lfmc_pkg::PH_FOLLOW: begin
        if (mark_left || mark_right) begin
          seen_left_nxt  = mark_left;
          seen_right_nxt = mark_right;
          phase_nxt      = lfmc_pkg::PH_CREEP;
          pwm_left_nxt   = cfg_r.creep_speed;
          pwm_right_nxt  = cfg_r.creep_speed;
        end else begin
          use_pd = 1'b1;
        end
      end
      lfmc_pkg::PH_CREEP: begin
        if (s_r[1] > cfg_r.clear_level || s_r[6] > cfg_r.clear_level) begin
          pwm_left_nxt  = cfg_r.creep_speed;
          pwm_right_nxt = cfg_r.creep_speed;
        end else if ((seen_left_r && seen_right_r) || s_r[3] > cfg_r.line_threshold
                     || s_r[4] > cfg_r.line_threshold) begin
          phase_nxt = lfmc_pkg::PH_DONE;
          fin_nxt   = 1'b1;
        end else begin
          hdl_nxt       = seen_left_r;
          hdr_nxt       = !seen_left_r;
          phase_nxt     = seen_left_r ? lfmc_pkg::PH_LEFT_SWING : lfmc_pkg::PH_RIGHT_SWING;
          pwm_left_nxt  = cfg_r.base_speed;
          pwm_right_nxt = cfg_r.base_speed;
        end
      end
      lfmc_pkg::PH_LEFT_SWING, lfmc_pkg::PH_LEFT_SETTLE,
      lfmc_pkg::PH_RIGHT_SWING, lfmc_pkg::PH_RIGHT_SETTLE: begin
        if (swing && outer < cfg_r.line_threshold) begin
          pwm_left_nxt  = cfg_r.base_speed;
          pwm_right_nxt = cfg_r.base_speed;
        end else if (centre < cfg_r.line_threshold) begin
          phase_nxt     = turn_left ? lfmc_pkg::PH_LEFT_SETTLE : lfmc_pkg::PH_RIGHT_SETTLE;
          pwm_left_nxt  = cfg_r.slow_speed;
          pwm_right_nxt = cfg_r.slow_speed;
        end else begin
          phase_nxt = lfmc_pkg::PH_FOLLOW;
          use_pd    = 1'b1;
        end
      end
      lfmc_pkg::PH_DONE: begin
        fin_nxt = 1'b1;
      end
      default: begin
        phase_nxt = lfmc_pkg::PH_DONE;
        fin_nxt   = 1'b1;
      end
    endcase

    if (use_pd) begin
      pwm_left_nxt  = pd_out.pwm_left;
      pwm_right_nxt = pd_out.pwm_right;
      prev_err_nxt  = pd_out.error;
      first_nxt     = 1'b0;
      hdl_nxt       = 1'b0;
      hdr_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= lfmc_pkg::PH_FOLLOW;
      seen_left_r  <= 1'b0;
      seen_right_r <= 1'b0;
      prev_err_r   <= '0;
      first_r      <= 1'b1;
      hdl_r        <= 1'b0;
      hdr_r        <= 1'b0;
    end else if (adv) begin
      phase_r      <= phase_nxt;
      seen_left_r  <= seen_left_nxt;
      seen_right_r <= seen_right_nxt;
      prev_err_r   <= prev_err_nxt;
      first_r      <= first_nxt;
      hdl_r        <= hdl_nxt;
      hdr_r        <= hdr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pwm_left_r  <= pwm_left_nxt;
      pwm_right_r <= pwm_right_nxt;
      dir_left_r  <= hdl_nxt;
      dir_right_r <= hdr_nxt;
      fin_r       <= fin_nxt;
    end
  end

endmodule
`default_nettype wire

### src/lfmc_checker.sv
`default_nettype none
module lfmc_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_pwm_left,
  input wire [7:0] out_pwm_right,
  input wire       out_dir_left,
  input wire       out_dir_right,
  input wire       out_finished
);

  logic seen_fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_fin_r <= 1'b0;
    end else if (out_valid && out_ready && out_finished) begin
      seen_fin_r <= 1'b1;
    end
  end

  // Once a finished command has been transferred, every later command is finished.
  a_finish_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_fin_r |-> out_finished)
    else $error("finished command followed by an unfinished one");

  a_finish_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_pwm_left == 8'd0 && out_pwm_right == 8'd0)
    else $error("finished command with motors running");

  a_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_dir_left && out_dir_right))
    else $error("both direction bits set");

  // During a turn both motors run at the same level.
  a_turn_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_dir_left || out_dir_right) && !out_finished
    |-> out_pwm_left == out_pwm_right)
    else $error("uneven PWM during a turn");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("command valid right after reset");

endmodule

bind line_follow_motor_controller lfmc_checker u_lfmc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_pwm_left  (out_pwm_left),
  .out_pwm_right (out_pwm_right),
  .out_dir_left  (out_dir_left),
  .out_dir_right (out_dir_right),
  .out_finished  (out_finished)
);
`default_nettype wire

### sim/tb_line_follow_motor_controller.sv
`timescale 1ns / 1ps
module tb_line_follow_motor_controller;
  import lfmc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 155;

  typedef struct packed {
    logic [SENSE_W-1:0] right_outer;
    logic [SENSE_W-1:0] right_near;
    logic [SENSE_W-1:0] right_mid;
    logic [SENSE_W-1:0] right_centre;
    logic [SENSE_W-1:0] left_centre;
    logic [SENSE_W-1:0] left_mid;
    logic [SENSE_W-1:0] left_near;
    logic [SENSE_W-1:0] left_outer;
    logic [POS_W-1:0]   position;
  } sensor_scan_t;

  typedef struct packed {
    logic [7:0] pwm_left;
    logic [7:0] pwm_right;
    logic       dir_left;
    logic       dir_right;
    logic       finished;
  } motor_cmd_t;

  class motor_command_checker;
    cfg_t                    regs;
    phase_t                  phase;
    bit                      seen_left;
    bit                      seen_right;
    bit                      first_sample;
    bit                      held_left;
    bit                      held_right;
    logic signed [ERR_W-1:0] prev_error;
    motor_cmd_t              expected_cmds[$];
    int                      mismatches;

    function new();
      regs = '{RST_BASE_SPEED, RST_SLOW_SPEED, RST_CREEP_SPEED, RST_KP, RST_KD,
               RST_CORR_LIMIT, RST_LINE_THRESH, RST_CLEAR_LEVEL};
      phase = PH_FOLLOW;
      seen_left = 0;
      seen_right = 0;
      first_sample = 1;
      held_left = 0;
      held_right = 0;
      prev_error = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_BASE_SPEED:  regs.base_speed = data[7:0];
        REG_SLOW_SPEED:  regs.slow_speed = data[7:0];
        REG_CREEP_SPEED: regs.creep_speed = data[7:0];
        REG_KP:          regs.kp_q16 = data;
        REG_KD:          regs.kd_q16 = data;
        REG_CORR_LIMIT:  regs.corr_clamp = data[6:0];
        REG_LINE_THRESH: regs.line_threshold = data[SENSE_W-1:0];
        REG_CLEAR_LEVEL: regs.clear_level = data[SENSE_W-1:0];
        default: ;
      endcase
    endfunction

    function motor_cmd_t make_cmd(logic [7:0] pl, logic [7:0] pr, logic fin);
      motor_cmd_t c;
      c.pwm_left = pl;
      c.pwm_right = pr;
      c.dir_left = held_left;
      c.dir_right = held_right;
      c.finished = fin;
      return c;
    endfunction

    function logic [7:0] clip_pwm(longint v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return 8'(v);
    endfunction

    function motor_cmd_t steer(logic [POS_W-1:0] position);
      longint pos;
      longint err;
      longint sum;
      longint mag;
      pos = (position > MAX_POSITION) ? longint'(MAX_POSITION) : longint'(position);
      err = pos - longint'(CENTRE_POSITION);
      sum = longint'(regs.kp_q16) * err;
      if (first_sample) first_sample = 0;
      else sum += longint'(regs.kd_q16) * (err - longint'(prev_error));
      prev_error = ERR_W'(err);
      mag = (sum < 0) ? -sum : sum;
      mag = mag >> 16;
      if (mag > longint'(regs.corr_clamp)) mag = longint'(regs.corr_clamp);
      if (sum < 0) mag = -mag;
      held_left = 0;
      held_right = 0;
      return make_cmd(clip_pwm(longint'(regs.base_speed) - mag),
                      clip_pwm(longint'(regs.base_speed) + mag), 1'b0);
    endfunction

    function void note_sample(sensor_scan_t s);
      bit                 right_mark;
      bit                 left_mark;
      bit                 left_turn;
      logic [SENSE_W-1:0] outer;
      logic [SENSE_W-1:0] centre;
      motor_cmd_t         cmd;
      case (phase)
        PH_FOLLOW: begin
          right_mark = s.right_outer == FULL_READING && s.right_near == FULL_READING &&
                       s.right_mid == FULL_READING;
          left_mark = s.left_outer == FULL_READING && s.left_near == FULL_READING &&
                      s.left_mid == FULL_READING;
          if (left_mark || right_mark) begin
            seen_left = left_mark;
            seen_right = right_mark;
            phase = PH_CREEP;
            cmd = make_cmd(regs.creep_speed, regs.creep_speed, 1'b0);
          end else begin
            cmd = steer(s.position);
          end
        end
        PH_CREEP: begin
          if (s.right_near > regs.clear_level || s.left_near > regs.clear_level) begin
            cmd = make_cmd(regs.creep_speed, regs.creep_speed, 1'b0);
          end else if ((seen_left && seen_right) || s.right_centre > regs.line_threshold ||
                       s.left_centre > regs.line_threshold) begin
            phase = PH_DONE;
            cmd = make_cmd(8'd0, 8'd0, 1'b1);
          end else begin
            held_left = seen_left;
            held_right = !seen_left;
            phase = seen_left ? PH_LEFT_SWING : PH_RIGHT_SWING;
            cmd = make_cmd(regs.base_speed, regs.base_speed, 1'b0);
          end
        end
        PH_LEFT_SWING, PH_LEFT_SETTLE, PH_RIGHT_SWING, PH_RIGHT_SETTLE: begin
          left_turn = (phase == PH_LEFT_SWING || phase == PH_LEFT_SETTLE);
          outer = left_turn ? s.left_outer : s.right_outer;
          centre = left_turn ? s.left_centre : s.right_centre;
          if ((phase == PH_LEFT_SWING || phase == PH_RIGHT_SWING) &&
              outer < regs.line_threshold) begin
            cmd = make_cmd(regs.base_speed, regs.base_speed, 1'b0);
          end else if (centre < regs.line_threshold) begin
            phase = left_turn ? PH_LEFT_SETTLE : PH_RIGHT_SETTLE;
            cmd = make_cmd(regs.slow_speed, regs.slow_speed, 1'b0);
          end else begin
            phase = PH_FOLLOW;
            cmd = steer(s.position);
          end
        end
        default: begin
          phase = PH_DONE;
          cmd = make_cmd(8'd0, 8'd0, 1'b1);
        end
      endcase
      expected_cmds.push_back(cmd);
    endfunction

    function void check_command(motor_cmd_t got);
      motor_cmd_t want;
      if (expected_cmds.size() == 0) begin
        $error("motor command transfer with no sensor scan pending");
        mismatches++;
        return;
      end
      want = expected_cmds.pop_front();
      if (got.pwm_left !== want.pwm_left) begin
        $error("pwm_left: expected %0d, actual %0d", want.pwm_left, got.pwm_left);
        mismatches++;
      end
      if (got.pwm_right !== want.pwm_right) begin
        $error("pwm_right: expected %0d, actual %0d", want.pwm_right, got.pwm_right);
        mismatches++;
      end
      if (got.dir_left !== want.dir_left) begin
        $error("dir_left: expected %0d, actual %0d", want.dir_left, got.dir_left);
        mismatches++;
      end
      if (got.dir_right !== want.dir_right) begin
        $error("dir_right: expected %0d, actual %0d", want.dir_right, got.dir_right);
        mismatches++;
      end
      if (got.finished !== want.finished) begin
        $error("finished: expected %0d, actual %0d", want.finished, got.finished);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_write_en = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  sensor_scan_t       in_item = '0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [7:0]         out_pwm_left;
  logic [7:0]         out_pwm_right;
  logic               out_dir_left;
  logic               out_dir_right;
  logic               out_finished;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 quiet_cycles = 0;
  motor_command_checker board;

  line_follow_motor_controller dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_write_en          (cfg_write_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_sense_right_outer  (in_item.right_outer),
    .in_sense_right_near   (in_item.right_near),
    .in_sense_right_mid    (in_item.right_mid),
    .in_sense_right_centre (in_item.right_centre),
    .in_sense_left_centre  (in_item.left_centre),
    .in_sense_left_mid     (in_item.left_mid),
    .in_sense_left_near    (in_item.left_near),
    .in_sense_left_outer   (in_item.left_outer),
    .in_line_position      (in_item.position),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_pwm_left          (out_pwm_left),
    .out_pwm_right         (out_pwm_right),
    .out_dir_left          (out_dir_left),
    .out_dir_right         (out_dir_right),
    .out_finished          (out_finished)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      board.check_command(motor_cmd_t'({out_pwm_left, out_pwm_right, out_dir_left,
                                        out_dir_right, out_finished}));
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic sensor_scan_t scan(int ro, int rn, int rm, int rc, int lc, int lm,
                                        int ln, int lo, int pos);
    sensor_scan_t s;
    s.right_outer = SENSE_W'(ro);
    s.right_near = SENSE_W'(rn);
    s.right_mid = SENSE_W'(rm);
    s.right_centre = SENSE_W'(rc);
    s.left_centre = SENSE_W'(lc);
    s.left_mid = SENSE_W'(lm);
    s.left_near = SENSE_W'(ln);
    s.left_outer = SENSE_W'(lo);
    s.position = POS_W'(pos);
    return s;
  endfunction

  function automatic int rnd_level();
    case ($urandom_range(7))
      0: return 0;
      1: return 1000;
      2: return 1023;
      default: return $urandom_range(1023, 0);
    endcase
  endfunction

  function automatic int rnd_position();
    case ($urandom_range(9))
      0: return 0;
      1: return 7000;
      2: return $urandom_range(8191, 7001);
      3: return 3500;
      default: return $urandom_range(7000, 0);
    endcase
  endfunction

  // Most scans follow the course of a real run so that marks, creeps and
  // turns keep coming; the stop cases are left for the end of the run.
  function automatic sensor_scan_t next_scan();
    sensor_scan_t s;
    int           thr;
    int           clr;
    int           v;
    thr = board.regs.line_threshold;
    clr = board.regs.clear_level;
    s = scan(rnd_level(), rnd_level(), rnd_level(), rnd_level(), rnd_level(), rnd_level(),
             rnd_level(), rnd_level(), rnd_position());
    case (board.phase)
      PH_FOLLOW: begin
        if ($urandom_range(99) < 12) begin
          if ($urandom_range(1)) begin
            {s.left_mid, s.left_near, s.left_outer} = {3{FULL_READING}};
          end else begin
            {s.right_outer, s.right_near, s.right_mid} = {3{FULL_READING}};
          end
        end
        if (s.left_mid == FULL_READING && s.left_near == FULL_READING &&
            s.left_outer == FULL_READING && s.right_outer == FULL_READING &&
            s.right_near == FULL_READING && s.right_mid == FULL_READING) begin
          if ($urandom_range(1)) s.right_mid = '0;
          else s.left_mid = '0;
        end
      end
      PH_CREEP: begin
        if (clr < 1023 && $urandom_range(99) < 55) begin
          if ($urandom_range(1)) s.right_near = SENSE_W'($urandom_range(1023, clr + 1));
          else s.left_near = SENSE_W'($urandom_range(1023, clr + 1));
        end else begin
          s.right_near = SENSE_W'($urandom_range(clr, 0));
          s.left_near = SENSE_W'($urandom_range(clr, 0));
          s.right_centre = SENSE_W'($urandom_range(thr, 0));
          s.left_centre = SENSE_W'($urandom_range(thr, 0));
        end
      end
      PH_LEFT_SWING, PH_RIGHT_SWING: begin
        v = (thr > 0 && $urandom_range(99) < 65) ? $urandom_range(thr - 1, 0)
                                                 : $urandom_range(1023, thr);
        if (board.phase == PH_LEFT_SWING) s.left_outer = SENSE_W'(v);
        else s.right_outer = SENSE_W'(v);
      end
      PH_LEFT_SETTLE, PH_RIGHT_SETTLE: begin
        v = (thr > 0 && $urandom_range(99) < 60) ? $urandom_range(thr - 1, 0)
                                                 : $urandom_range(1023, thr);
        if (board.phase == PH_LEFT_SETTLE) s.left_centre = SENSE_W'(v);
        else s.right_centre = SENSE_W'(v);
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic cfg_t pick_setting(int kind);
    cfg_t c;
    case (kind)
      0: c = '{8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 7'd127, 10'd1000, 10'd1000};
      1: c = '0;
      default: begin
        c.base_speed = 8'($urandom_range(255));
        c.slow_speed = 8'($urandom_range(255));
        c.creep_speed = 8'($urandom_range(255));
        c.kp_q16 = 16'($urandom_range(65535));
        c.kd_q16 = $urandom_range(1) ? 16'($urandom_range(65535)) : 16'($urandom_range(4000));
        c.corr_clamp = 7'($urandom_range(127));
        c.line_threshold = SENSE_W'($urandom_range(1000));
        c.clear_level = SENSE_W'($urandom_range(1000));
      end
    endcase
    return c;
  endfunction

  task automatic send_scan(sensor_scan_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_item = s;
    do @(posedge clk); while (in_ready !== 1'b1);
    board.note_sample(s);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.expected_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    board.write_reg(idx, data);
  endtask

  task automatic load_setting(cfg_t c);
    put_reg(REG_BASE_SPEED, CFG_W'(c.base_speed));
    put_reg(REG_SLOW_SPEED, CFG_W'(c.slow_speed));
    put_reg(REG_CREEP_SPEED, CFG_W'(c.creep_speed));
    put_reg(REG_KP, c.kp_q16);
    put_reg(REG_KD, c.kd_q16);
    put_reg(REG_CORR_LIMIT, CFG_W'(c.corr_clamp));
    put_reg(REG_LINE_THRESH, CFG_W'(c.line_threshold));
    put_reg(REG_CLEAR_LEVEL, CFG_W'(c.clear_level));
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  initial begin
    int variant;
    board = new();
    send_idle_pct = 37;
    recv_idle_pct = 86;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    send_scan(scan(0, 0, 0, 0, 0, 0, 0, 0, 3500));
    send_scan(scan(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_scan(scan(0, 0, 0, 0, 0, 0, 0, 0, 7000));
    send_scan(scan(0, 0, 0, 0, 0, 0, 0, 0, 8191));
    send_scan(scan(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 4000));
    send_scan(scan(1000, 1000, 1000, 0, 0, 0, 0, 0, 3500));
    send_scan(scan(0, 600, 0, 0, 0, 0, 0, 0, 3500));
    send_scan(scan(0, 0, 0, 0, 0, 0, 600, 0, 3500));
    send_scan(scan(0, 0, 0, 0, 0, 0, 0, 0, 3500));
    send_scan(scan(200, 0, 0, 0, 0, 0, 0, 0, 3500));
    send_scan(scan(500, 0, 0, 499, 0, 0, 0, 0, 3500));
    send_scan(scan(0, 0, 0, 300, 0, 0, 0, 0, 3500));
    send_scan(scan(0, 0, 0, 500, 0, 0, 0, 0, 2000));
    send_scan(scan(0, 1000, 0, 0, 0, 1000, 1000, 1000, 5000));
    send_scan(scan(0, 100, 0, 500, 500, 0, 100, 0, 3500));
    send_scan(scan(0, 0, 0, 0, 1000, 0, 0, 1000, 1200));
    send_scan(scan(0, 0, 0, 0, 0, 0, 0, 0, 3499));
    send_scan(scan(0, 0, 0, 0, 0, 0, 0, 0, 7001));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      repeat (4) @(negedge clk);
      load_setting(pick_setting(p));
      case (p / 2)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 2 && i == 70) drain();
        send_scan(next_scan());
      end
    end

    // Bring the controller back to line following, then end the course.
    while (board.phase != PH_FOLLOW) begin
      if (board.phase == PH_CREEP) send_scan(scan(0, 0, 0, 0, 0, 0, 0, 0, 3500));
      else send_scan(scan(1023, 0, 0, 1023, 1023, 0, 0, 1023, 3500));
    end
    variant = $urandom_range(2);
    case (variant)
      0: begin
        send_scan(scan(1000, 1000, 1000, 0, 0, 1000, 1000, 1000, 3500));
        send_scan(scan(0, 0, 0, 0, 0, 0, 0, 0, 3500));
      end
      1: begin
        send_scan(scan(0, 0, 0, 0, 0, 1000, 1000, 1000, 3500));
        send_scan(scan(0, 0, 0, 1023, 0, 0, 0, 0, 3500));
      end
      default: begin
        send_scan(scan(1000, 1000, 1000, 0, 0, 0, 0, 0, 3500));
        send_scan(scan(0, 0, 0, 0, 1023, 0, 0, 0, 3500));
      end
    endcase
    repeat (3) send_scan(next_scan());

    drain();
    repeat (8) @(posedge clk);
    if (board.expected_cmds.size() != 0) begin
      $error("%0d motor commands never arrived", board.expected_cmds.size());
      board.mismatches++;
    end
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
